// ----- rtl/core/delta_sigma_pwm_ramp_driver_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the delta-sigma PWM ramp driver core
// Shared property forms used by the core's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef DELTA_SIGMA_PWM_RAMP_DRIVER_CORE_ASSERT_SVH
`define DELTA_SIGMA_PWM_RAMP_DRIVER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSPR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/dspr_pkg.sv -----
// ----------------------------------------------------------------------------
// Delta-sigma PWM ramp driver package
// Word types, event codes, state layout and the ramp step helper.
// ----------------------------------------------------------------------------
package dspr_pkg;

   localparam int LEVEL_WIDTH = 15;
   localparam int FRAC_BITS   = 7;
   localparam int PWM_WIDTH   = 8;
   localparam int STEP_WIDTH  = 7;

   localparam logic [LEVEL_WIDTH-1:0] FULL_LEVEL_RESET = 15'd32640;
   localparam logic [STEP_WIDTH-1:0]  FET_STEPS        = 7'd4;

   // Event codes carried in req_type.
   localparam logic [1:0] EVT_OFF    = 2'd0;
   localparam logic [1:0] EVT_SET    = 2'd1;
   localparam logic [1:0] EVT_RAMP   = 2'd2;
   localparam logic [1:0] EVT_PERIOD = 2'd3;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [LEVEL_WIDTH-1:0] ch1_target;
      logic [PWM_WIDTH-1:0]   fet_target;
      logic                   was_off;
   } dspr_req_word_type;

   typedef struct packed {
      logic [PWM_WIDTH-1:0] ch1_pwm;
      logic [PWM_WIDTH-1:0] fet_pwm;
      logic                 ch1_enable;
      logic                 dither_active;
      logic                 phase_reset;
      logic                 ramp_done;
   } dspr_rsp_word_type;

   // The accumulator is masked back below 128 after every period tick, so
   // seven bits hold it.
   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] level;
      logic [FRAC_BITS-1:0]   accumulator;
      logic [PWM_WIDTH-1:0]   pwm_next;
      logic [PWM_WIDTH-1:0]   pwm_applied;
      logic [PWM_WIDTH-1:0]   fet_duty;
      logic                   amp_enable;
      logic                   dither_on;
   } dspr_state_type;

   // Moves cur toward tgt by at most n, landing exactly on tgt when close.
   function automatic logic [LEVEL_WIDTH-1:0] move_toward(
      input logic [LEVEL_WIDTH-1:0] cur,
      input logic [LEVEL_WIDTH-1:0] tgt,
      input logic [STEP_WIDTH-1:0]  n
   );
      logic [LEVEL_WIDTH-1:0] diff;
      logic [LEVEL_WIDTH-1:0] step;
      logic [LEVEL_WIDTH-1:0] result;
      step   = {{(LEVEL_WIDTH-STEP_WIDTH){1'b0}}, n};
      result = cur;
      if (cur < tgt) begin
         diff   = tgt - cur;
         result = (diff > step) ? cur + step : tgt;
      end else if (cur > tgt) begin
         diff   = cur - tgt;
         result = (diff > step) ? cur - step : tgt;
      end
      return result;
   endfunction

endpackage

// ----- rtl/core/dspr_update.sv -----
// ----------------------------------------------------------------------------
// Delta-sigma PWM ramp driver state update
// Computes the next driver state and the result word for one event.
// ----------------------------------------------------------------------------
module dspr_update (
   input  logic [14:0]                 full_level,
   input  dspr_pkg::dspr_req_word_type req_word,
   input  dspr_pkg::dspr_state_type    state_cur,
   output dspr_pkg::dspr_state_type    state_nxt,
   output dspr_pkg::dspr_rsp_word_type rsp_word
);
   import dspr_pkg::*;

   logic [LEVEL_WIDTH-1:0] tgt;
   logic [LEVEL_WIDTH-1:0] lvl_jump;
   logic [STEP_WIDTH-1:0]  ramp_step;
   logic [LEVEL_WIDTH-1:0] fet_moved;
   logic [PWM_WIDTH-1:0]   acc_sum;
   logic [PWM_WIDTH:0]     nxt_sum;
   logic                   phase;
   logic                   done;

   always_comb begin
      tgt = (req_word.ch1_target > full_level) ? full_level : req_word.ch1_target;

      // Ramping snaps straight between zero and full level.
      if (((state_cur.level == full_level) && (tgt == '0)) ||
          ((tgt == full_level) && (state_cur.level == '0))) begin
         lvl_jump = tgt;
      end else begin
         lvl_jump = state_cur.level;
      end
      ramp_step = {1'b0, lvl_jump[LEVEL_WIDTH-1:9]} + STEP_WIDTH'(1);
      fet_moved = move_toward({{(LEVEL_WIDTH-PWM_WIDTH){1'b0}}, state_cur.fet_duty},
                              {{(LEVEL_WIDTH-PWM_WIDTH){1'b0}}, req_word.fet_target},
                              FET_STEPS);

      acc_sum = {1'b0, state_cur.accumulator} + {1'b0, state_cur.level[FRAC_BITS-1:0]};
      nxt_sum = {1'b0, state_cur.level[LEVEL_WIDTH-1:FRAC_BITS]} +
                {{PWM_WIDTH{1'b0}}, acc_sum[PWM_WIDTH-1]};

      state_nxt = state_cur;
      phase     = 1'b0;
      done      = 1'b0;

      case (req_word.req_type)
         EVT_OFF: begin
            state_nxt.level       = '0;
            state_nxt.pwm_applied = '0;
            state_nxt.fet_duty    = '0;
            state_nxt.amp_enable  = 1'b0;
            state_nxt.dither_on   = 1'b0;
            phase                 = 1'b1;
         end
         EVT_SET: begin
            state_nxt.level       = tgt;
            state_nxt.pwm_next    = tgt[LEVEL_WIDTH-1:FRAC_BITS];
            state_nxt.pwm_applied = tgt[LEVEL_WIDTH-1:FRAC_BITS];
            state_nxt.fet_duty    = req_word.fet_target;
            state_nxt.amp_enable  = 1'b1;
            state_nxt.dither_on   = 1'b1;
            phase                 = req_word.was_off;
         end
         EVT_RAMP: begin
            state_nxt.level    = move_toward(lvl_jump, tgt, ramp_step);
            state_nxt.fet_duty = fet_moved[PWM_WIDTH-1:0];
            done = (state_nxt.level == tgt) && (state_nxt.fet_duty == req_word.fet_target);
         end
         EVT_PERIOD: begin
            if (state_cur.dither_on) begin
               state_nxt.pwm_applied = state_cur.pwm_next;
               state_nxt.accumulator = acc_sum[FRAC_BITS-1:0];
               // A carry out of integer part 255 saturates.
               state_nxt.pwm_next = nxt_sum[PWM_WIDTH] ? {PWM_WIDTH{1'b1}}
                                                       : nxt_sum[PWM_WIDTH-1:0];
            end
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase

      rsp_word.ch1_pwm       = state_nxt.pwm_applied;
      rsp_word.fet_pwm       = state_nxt.fet_duty;
      rsp_word.ch1_enable    = state_nxt.amp_enable;
      rsp_word.dither_active = state_nxt.dither_on;
      rsp_word.phase_reset   = phase;
      rsp_word.ramp_done     = done;
   end

endmodule

// ----- rtl/core/delta_sigma_pwm_ramp_driver_core.sv -----
// ----------------------------------------------------------------------------
// Delta-sigma PWM ramp driver core
// Event-driven LED driver: dithered linear channel plus FET PWM channel.
// ----------------------------------------------------------------------------
// Each request word is one event (switch off, set levels, ramp tick or PWM
// period tick) and yields exactly one response word, in order. A word is
// captured in an input register, its state update is done in
// combinational logic, and the result lands in an output register. rsp_valid
// rises when the word moves on from the input register to the output
// register, which it does only while that register is empty or draining;
// with rsp_ready high the core sustains one word per cycle, a rate that rests
// on the state update loop being purely combinational. While a finished
// response waits for rsp_ready, the input register still takes one more
// word and then req_ready stays low until the response drains. full_level
// is written through csr_write_enable / csr_write_data and must only change
// while the core is idle; it resets to 32640.
module delta_sigma_pwm_ramp_driver_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  dspr_pkg::dspr_req_word_type req_word,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output dspr_pkg::dspr_rsp_word_type rsp_word,
   input  logic                        csr_write_enable,
   input  logic [14:0]                 csr_write_data
);
   import dspr_pkg::*;

   `include "delta_sigma_pwm_ramp_driver_core_assert.svh"

   // Configuration register.
   logic [LEVEL_WIDTH-1:0] full_level_ff;
   logic [LEVEL_WIDTH-1:0] full_level_in;

   // Input stage.
   logic              s1_valid_ff;
   logic              s1_valid_in;
   dspr_req_word_type s1_word_ff;
   dspr_req_word_type s1_word_in;

   // Driver state carried from event to event.
   dspr_state_type state_ff;
   dspr_state_type state_in;
   dspr_state_type state_upd;

   // Output stage.
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   dspr_rsp_word_type  rsp_word_ff;
   dspr_rsp_word_type  rsp_word_in;
   dspr_rsp_word_type  rsp_word_upd;

   logic req_accept;
   logic advance;
   logic fire;

   // Terms watched by the assertions.
   logic dither_now;
   logic amp_now;
   logic off_rsp;
   logic off_idle;

   // The output register can take a new word when it is empty or being
   // drained this cycle. The input stage fires into it under that condition,
   // and the input register reopens as soon as its word moves on.
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign fire       = s1_valid_ff && advance;
   assign req_ready  = !s1_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   dspr_update u_update (
      .full_level (full_level_ff),
      .req_word   (s1_word_ff),
      .state_cur  (state_ff),
      .state_nxt  (state_upd),
      .rsp_word   (rsp_word_upd)
   );

   always_comb begin
      full_level_in = csr_write_enable ? csr_write_data : full_level_ff;

      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      s1_word_in = req_accept ? req_word : s1_word_ff;

      // State only advances when the event's response is committed, so the
      // next event always sees the state this one leaves.
      state_in = fire ? state_upd : state_ff;

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_word_in = fire ? rsp_word_upd : rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_level_ff <= FULL_LEVEL_RESET;
         s1_valid_ff   <= 1'b0;
         state_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         full_level_ff <= full_level_in;
         s1_valid_ff   <= s1_valid_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      s1_word_ff  <= s1_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign dither_now = state_ff.dither_on;
   assign amp_now    = state_ff.amp_enable;
   assign off_rsp    = rsp_valid_ff && rsp_word_ff.phase_reset && !rsp_word_ff.ch1_enable;
   assign off_idle   = (rsp_word_ff.ch1_pwm == '0) && (rsp_word_ff.fet_pwm == '0) &&
                       !rsp_word_ff.dither_active;

   // Dithering is only ever enabled together with the amplifier.
   `DSPR_ASSERT_SAME(a_dither_needs_amp, clock, reset, dither_now, amp_now, "dither without amp")

   // A pending input word that may advance shows up as a response next cycle.
   `DSPR_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, fire, rsp_valid_ff, "word lost")

   // A phase reset with the amplifier off can only come from switch off.
   `DSPR_ASSERT_SAME(a_off_clears, clock, reset, off_rsp, off_idle, "outputs left on")

endmodule

// ----- tb/delta_sigma_pwm_ramp_driver_core_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Delta-sigma PWM ramp driver checker
// Watches both word channels and the full_level write port, predicts each
// response word from the accepted request words and compares field by field.
// ----------------------------------------------------------------------------
module delta_sigma_pwm_ramp_driver_core_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  dspr_pkg::dspr_req_word_type req_word,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  dspr_pkg::dspr_rsp_word_type rsp_word,
   input  logic                        csr_write_enable,
   input  logic [14:0]                 csr_write_data,
   output int                          fail_count,
   output int                          pending_count
);
   import dspr_pkg::*;

   // Shadow copy of the driver state.
   logic [14:0] full_level_q;
   logic [14:0] level_q;
   logic [7:0]  accum_q;
   logic [7:0]  pwm_next_q;
   logic [7:0]  pwm_applied_q;
   logic [7:0]  fet_duty_q;
   logic        amp_enable_q;
   logic        dither_on_q;

   dspr_rsp_word_type expected_rsp_q[$];
   int                mismatch_total = 0;
   int                outstanding    = 0;

   assign fail_count    = mismatch_total;
   assign pending_count = outstanding;

   function automatic int step_toward(input int cur, input int tgt, input int n);
      if (cur < tgt)
         return (tgt - cur > n) ? cur + n : tgt;
      if (cur > tgt)
         return (cur - tgt > n) ? cur - n : tgt;
      return cur;
   endfunction

   // Applies one event to the shadow state and returns the response it yields.
   function automatic dspr_rsp_word_type apply_led_event(input dspr_req_word_type w);
      dspr_rsp_word_type r;
      int                tgt;
      int                acc_sum;
      int                nxt;
      logic              phase;
      logic              done;
      tgt   = int'(w.ch1_target);
      phase = 1'b0;
      done  = 1'b0;
      if (tgt > int'(full_level_q))
         tgt = int'(full_level_q);
      case (w.req_type)
         EVT_OFF: begin
            level_q       = '0;
            pwm_applied_q = '0;
            fet_duty_q    = '0;
            amp_enable_q  = 1'b0;
            dither_on_q   = 1'b0;
            phase         = 1'b1;
         end
         EVT_SET: begin
            amp_enable_q  = 1'b1;
            level_q       = tgt[14:0];
            pwm_next_q    = level_q[14:7];
            pwm_applied_q = level_q[14:7];
            fet_duty_q    = w.fet_target;
            dither_on_q   = 1'b1;
            phase         = w.was_off;
         end
         EVT_RAMP: begin
            // Snap straight across when going between off and full.
            if ((level_q == full_level_q && tgt == 0) ||
                (tgt == int'(full_level_q) && level_q == '0))
               level_q = tgt[14:0];
            fet_duty_q = 8'(step_toward(int'(fet_duty_q), int'(w.fet_target),
                                        int'(FET_STEPS)));
            level_q    = 15'(step_toward(int'(level_q), tgt, int'(level_q >> 9) + 1));
            done       = (int'(level_q) == tgt) && (fet_duty_q == w.fet_target);
         end
         EVT_PERIOD: begin
            if (dither_on_q) begin
               pwm_applied_q = pwm_next_q;
               acc_sum       = int'(accum_q) + int'(level_q[6:0]);
               nxt           = int'(level_q[14:7]) + ((acc_sum > 127) ? 1 : 0);
               pwm_next_q    = (nxt > 255) ? 8'd255 : nxt[7:0];
               accum_q       = acc_sum[7:0] & 8'h7f;
            end
         end
         default: begin
         end
      endcase
      r.ch1_pwm       = pwm_applied_q;
      r.fet_pwm       = fet_duty_q;
      r.ch1_enable    = amp_enable_q;
      r.dither_active = dither_on_q;
      r.phase_reset   = phase;
      r.ramp_done     = done;
      return r;
   endfunction

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_total++;
      end
   endtask

   always @(posedge clock) begin
      dspr_rsp_word_type want;
      if (reset) begin
         full_level_q  = FULL_LEVEL_RESET;
         level_q       = '0;
         accum_q       = '0;
         pwm_next_q    = '0;
         pwm_applied_q = '0;
         fet_duty_q    = '0;
         amp_enable_q  = 1'b0;
         dither_on_q   = 1'b0;
         expected_rsp_q.delete();
      end else begin
         if (csr_write_enable)
            full_level_q = csr_write_data;
         if (req_valid && req_ready)
            expected_rsp_q.push_back(apply_led_event(req_word));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response word arrived with no expected word pending");
               mismatch_total++;
            end else begin
               want = expected_rsp_q.pop_front();
               compare_field("ch1_pwm", int'(want.ch1_pwm), int'(rsp_word.ch1_pwm));
               compare_field("fet_pwm", int'(want.fet_pwm), int'(rsp_word.fet_pwm));
               compare_field("ch1_enable", int'(want.ch1_enable),
                             int'(rsp_word.ch1_enable));
               compare_field("dither_active", int'(want.dither_active),
                             int'(rsp_word.dither_active));
               compare_field("phase_reset", int'(want.phase_reset),
                             int'(rsp_word.phase_reset));
               compare_field("ramp_done", int'(want.ramp_done),
                             int'(rsp_word.ramp_done));
            end
         end
      end
      outstanding <= expected_rsp_q.size();
   end

endmodule

// ----- tb/delta_sigma_pwm_ramp_driver_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Delta-sigma PWM ramp driver testbench
// Drives switch-off, set, ramp and period-tick words through the core under
// several full_level settings, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module delta_sigma_pwm_ramp_driver_core_tb;
   import dspr_pkg::*;

   // The watchdog ends the run after this many cycles without a handshake.
   localparam int IDLE_LIMIT       = 5000;
   // Length of the one long receiver hold-off.
   localparam int LONG_HOLD_CYCLES = 300;
   // Cycles to let pass once the core has drained, covering its latency.
   localparam int SETTLE_CYCLES    = 6;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   dspr_req_word_type req_word;
   logic              rsp_valid;
   logic              rsp_ready;
   dspr_rsp_word_type rsp_word;
   logic              csr_write_enable;
   logic [14:0]       csr_write_data;

   int                fail_count;
   int                pending_count;

   // Stimulus bookkeeping.
   int                items_sent = 0;
   int                burst_left = 0;
   bit                gaps_on    = 1'b1;
   bit                long_hold_req = 1'b0;
   logic [14:0]       full_level_now = FULL_LEVEL_RESET;

   delta_sigma_pwm_ramp_driver_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   delta_sigma_pwm_ramp_driver_core_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The watchdog counts cycles in which neither channel moves a word. Any
   // handshake clears it, so long but legal stalls never trip it.
   always @(posedge clock) begin
      int idle_cycles;
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // The receiver picks a stall pattern, keeps it for a while and then picks
   // another one. When the stimulus asks for it, it holds off for a long
   // stretch so that the core fills up and pushes back on its input.
   initial begin
      int      mode;
      int      mode_left;
      bit [2:0] pat;
      mode      = 0;
      mode_left = 0;
      pat       = '0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_req = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = int'($urandom_range(0, 3));
               mode_left = int'($urandom_range(16, 96));
            end
            mode_left--;
            pat++;
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= (pat == 3'd0) || (pat == 3'd3) || (pat == 3'd5);
               default: rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   function automatic dspr_req_word_type make_word(input logic [1:0]  kind,
                                                   input logic [14:0] tgt,
                                                   input logic [7:0]  ftgt,
                                                   input logic        woff);
      dspr_req_word_type w;
      w.req_type   = kind;
      w.ch1_target = tgt;
      w.fet_target = ftgt;
      w.was_off    = woff;
      return w;
   endfunction

   // Fully random word: every bit of every field gets exercised here.
   function automatic dspr_req_word_type noise_word();
      return make_word(2'($urandom_range(0, 3)), 15'($urandom_range(0, 32767)),
                       8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endfunction

   // Linear targets lean toward the interesting points: off, exactly full,
   // above full (clamped by the core) and anything in between.
   function automatic logic [14:0] pick_level();
      case ($urandom_range(0, 9))
         0:       return 15'd0;
         1:       return full_level_now;
         2:       return 15'($urandom_range(int'(full_level_now), 32767));
         3:       return 15'($urandom_range(0, 32767));
         4:       return 15'($urandom_range(0, 127));
         default: return 15'($urandom_range(0, int'(full_level_now)));
      endcase
   endfunction

   function automatic logic [7:0] pick_fet();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Offers one word and holds it until the core takes it. Valid stays high
   // afterwards so that a following word goes out back to back; the sender
   // idles only at the end of a burst.
   task automatic send_word(input dspr_req_word_type w);
      int gap;
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = int'($urandom_range(1, 16));
            gap        = int'($urandom_range(1, 6));
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Stops offering and waits until every expected response word is back.
   // The first edge lets the checker's count catch up with the last word.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called while the core is idle.
   task automatic write_full_level(input logic [14:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      full_level_now    = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Most of the random traffic is made of sequences that a real controller
   // would issue: a set followed by a run of period ticks so the dither
   // accumulator wraps many times, or a run of ramp ticks toward one target
   // so the ramp can converge. The rest is switch-off, snap and noise.
   task automatic random_sequences(input int count);
      int          stop_at;
      int          n;
      logic [14:0] tgt;
      logic [7:0]  ftgt;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               send_word(make_word(EVT_SET, pick_level(), pick_fet(),
                                   1'($urandom_range(0, 1))));
               n = int'($urandom_range(4, 40));
               repeat (n) send_word(make_word(EVT_PERIOD, 15'($urandom_range(0, 32767)),
                                              8'($urandom_range(0, 255)),
                                              1'($urandom_range(0, 1))));
            end
            3, 4, 5: begin
               tgt  = pick_level();
               ftgt = pick_fet();
               n    = int'($urandom_range(4, 60));
               repeat (n) begin
                  if ($urandom_range(0, 3) == 0)
                     send_word(make_word(EVT_PERIOD, tgt, ftgt,
                                         1'($urandom_range(0, 1))));
                  else
                     send_word(make_word(EVT_RAMP, tgt, ftgt,
                                         1'($urandom_range(0, 1))));
               end
            end
            6: begin
               send_word(make_word(EVT_OFF, 15'($urandom_range(0, 32767)),
                                   8'($urandom_range(0, 255)),
                                   1'($urandom_range(0, 1))));
               n = int'($urandom_range(1, 6));
               repeat (n) send_word(make_word($urandom_range(0, 1) ? EVT_PERIOD : EVT_RAMP,
                                              pick_level(), pick_fet(),
                                              1'($urandom_range(0, 1))));
            end
            7: begin
               // Snap from full to off and back again.
               send_word(make_word(EVT_SET, full_level_now, pick_fet(), 1'b0));
               send_word(make_word(EVT_RAMP, 15'd0, pick_fet(), 1'b0));
               send_word(make_word(EVT_RAMP,
                                   15'($urandom_range(int'(full_level_now), 32767)),
                                   pick_fet(), 1'b1));
            end
            default: begin
               n = int'($urandom_range(1, 8));
               repeat (n) send_word(noise_word());
            end
         endcase
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_word         <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening under the reset value of full_level. A period tick
      // before any set must do nothing since dithering is still off.
      gaps_on = 1'b0;
      send_word(make_word(EVT_PERIOD, 15'h7fff, 8'hff, 1'b1));
      send_word(make_word(EVT_OFF, 15'h7fff, 8'hff, 1'b1));
      // A target above full level is clamped.
      send_word(make_word(EVT_SET, 15'h7fff, 8'hff, 1'b1));
      send_word(make_word(EVT_PERIOD, 15'd0, 8'd0, 1'b0));
      send_word(make_word(EVT_PERIOD, 15'd0, 8'd0, 1'b0));
      // Integer part one with the largest fraction: the carry shows up on
      // almost every period.
      send_word(make_word(EVT_SET, 15'h00ff, 8'd0, 1'b0));
      repeat (4) send_word(make_word(EVT_PERIOD, 15'd0, 8'd0, 1'b0));
      send_word(make_word(EVT_RAMP, 15'd0, 8'd0, 1'b0));
      send_word(make_word(EVT_RAMP, 15'd0, 8'd0, 1'b0));
      // Snap from full down to zero, then from zero up to full.
      send_word(make_word(EVT_SET, FULL_LEVEL_RESET, 8'd10, 1'b0));
      send_word(make_word(EVT_RAMP, 15'd0, 8'd0, 1'b0));
      send_word(make_word(EVT_RAMP, FULL_LEVEL_RESET, 8'd255, 1'b0));
      send_word(make_word(EVT_RAMP, 15'h7fff, 8'd6, 1'b0));
      // Targets within one step land exactly and report done.
      send_word(make_word(EVT_SET, 15'd20000, 8'd100, 1'b1));
      send_word(make_word(EVT_RAMP, 15'd20003, 8'd102, 1'b0));
      send_word(make_word(EVT_RAMP, 15'd20003, 8'd102, 1'b0));
      send_word(make_word(EVT_OFF, 15'd0, 8'd0, 1'b0));
      send_word(make_word(EVT_PERIOD, 15'd0, 8'd0, 1'b0));
      random_sequences(200);
      wait_drained();

      // Smallest full level. Midway, the receiver holds off for a long
      // stretch while the sender keeps offering words back to back.
      write_full_level(15'd128);
      random_sequences(100);
      long_hold_req = 1'b1;
      gaps_on       = 1'b0;
      repeat (60) send_word(noise_word());
      random_sequences(100);
      wait_drained();

      // Largest full level in range. The sender also pauses midway until
      // every response is back, then carries on.
      write_full_level(15'd32640);
      random_sequences(100);
      wait_drained();
      random_sequences(100);
      wait_drained();

      write_full_level(15'($urandom_range(129, 32639)));
      random_sequences(200);
      wait_drained();

      // Full level above the top PWM code allows a fraction on integer part
      // 255, so the carry would reach 256 and must saturate.
      write_full_level(15'h7fff);
      gaps_on = 1'b0;
      send_word(make_word(EVT_SET, 15'h7fff, 8'd128, 1'b1));
      repeat (5) send_word(make_word(EVT_PERIOD, 15'd0, 8'd0, 1'b0));
      send_word(make_word(EVT_RAMP, 15'h7fff, 8'd128, 1'b0));
      send_word(make_word(EVT_OFF, 15'd0, 8'd0, 1'b0));
      random_sequences(150);
      wait_drained();

      write_full_level(15'd16384);
      random_sequences(200);
      wait_drained();

      if (fail_count == 0 && pending_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/dspr_pkg.sv
rtl/core/dspr_update.sv
rtl/core/delta_sigma_pwm_ramp_driver_core.sv
tb/delta_sigma_pwm_ramp_driver_core_checker.sv
tb/delta_sigma_pwm_ramp_driver_core_tb.sv
